@@ hdl/stack_vm_double_arith_core_defines.svh @@
// Assertion macros used by the checker file of the stack machine.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef STACK_VM_DOUBLE_ARITH_CORE_DEFINES_SVH
`define STACK_VM_DOUBLE_ARITH_CORE_DEFINES_SVH

// Same-cycle implication.
`define SVDAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SVDAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/svdac_pkg.sv @@
package svdac_pkg;

   localparam int STACK_DEPTH = 256;

   typedef enum logic [2:0] {
      CMD_CONST = 3'd0,
      CMD_ADD   = 3'd1,
      CMD_SUB   = 3'd2,
      CMD_MUL   = 3'd3,
      CMD_DIV   = 3'd4,
      CMD_NEG   = 3'd5,
      CMD_RET   = 3'd6,
      CMD_NOP   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_RSVD  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_READ_B, S_READ_A, S_SETUP, S_ALIGN, S_ADDSUB, S_MUL_P, S_MUL_A,
      S_PRENORM, S_DIV, S_NORM, S_DENORM, S_ROUND, S_WRITE, S_READ_T, S_TOP, S_EMIT
   } state_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] bits;
   } special_type;

   localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] INVALID_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [10:0] EXP_ONES    = 11'h7FF;

   function automatic logic is_nan(input logic [63:0] v);
      return (v[62:52] == EXP_ONES) && (v[51:0] != 52'd0);
   endfunction

   function automatic logic is_inf(input logic [63:0] v);
      return (v[62:52] == EXP_ONES) && (v[51:0] == 52'd0);
   endfunction

   function automatic logic is_zero(input logic [63:0] v);
      return v[62:0] == 63'd0;
   endfunction

   // Results that need no rounding: NaN, infinity and zero operands.
   function automatic special_type fp_special(input cmd_type op, input logic [63:0] a,
                                              input logic [63:0] b);
      special_type r;
      logic        sbe;
      logic        sx;
      r.hit  = 1'b1;
      r.bits = 64'd0;
      sbe    = b[63] ^ (op == CMD_SUB);
      sx     = a[63] ^ b[63];
      if (is_nan(a)) begin
         r.bits = a | QUIET_BIT;
      end else if (op == CMD_DIV && is_zero(b)) begin
         if (is_zero(a)) r.bits = DEFAULT_NAN;
         else r.bits = {sx, EXP_ONES, 52'd0};
      end else if (is_nan(b)) begin
         r.bits = b | QUIET_BIT;
      end else if (op == CMD_ADD || op == CMD_SUB) begin
         if (is_inf(a) && is_inf(b) && (a[63] != sbe)) r.bits = INVALID_NAN;
         else if (is_inf(a)) r.bits = a;
         else if (is_inf(b)) r.bits = {sbe, EXP_ONES, 52'd0};
         else if (is_zero(a) && is_zero(b)) r.bits = {a[63] & sbe, 63'd0};
         else if (is_zero(a)) r.bits = {sbe, b[62:0]};
         else if (is_zero(b)) r.bits = a;
         else r.hit = 1'b0;
      end else if (op == CMD_MUL) begin
         if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) r.bits = INVALID_NAN;
         else if (is_inf(a) || is_inf(b)) r.bits = {sx, EXP_ONES, 52'd0};
         else if (is_zero(a) || is_zero(b)) r.bits = {sx, 63'd0};
         else r.hit = 1'b0;
      end else begin
         if (is_inf(a) && is_inf(b)) r.bits = INVALID_NAN;
         else if (is_inf(a)) r.bits = {sx, EXP_ONES, 52'd0};
         else if (is_inf(b) || is_zero(a)) r.bits = {sx, 63'd0};
         else r.hit = 1'b0;
      end
      return r;
   endfunction

   // Right shift that folds every bit shifted out into the lowest bit.
   function automatic logic [63:0] shr_sticky(input logic [63:0] v, input logic [5:0] amt);
      logic [63:0] mask;
      logic [63:0] r;
      mask = (64'd1 << amt) - 64'd1;
      r    = v >> amt;
      r[0] = r[0] | (|(v & mask));
      return r;
   endfunction

endpackage

@@ hdl/stack_vm_double_arith_core.sv @@
// Channel   Direction  Transaction contents
// req_*     in         tuser[2:0] command, tdata[63:0] constant bits
// rsp_*     out        tuser[1:0] status, tdata[63:0] result bits
//
// One instruction is taken at a time; req_tready is high only while the sequencer idles.
// Divide runs longest: it prenormalizes a subnormal divisor and dividend one bit at a time
// and then runs the 57-step divider.
// Reset clears the stack pointer and the output register; the stack memory is not cleared.
// A pending result waits in the output register; an error or return waits while it is full.
module stack_vm_double_arith_core #(
   parameter int STACK_DEPTH = svdac_pkg::STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] constant_bits
   input  logic [2:0]  req_tuser,   // [2:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] result_bits
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   // Exponent bookkeeping: a working value is W times two to the power X.
   localparam logic signed [13:0] BIAS_OFS = 14'sd1078;
   localparam logic signed [13:0] MUL_OFS  = 14'sd2150;
   localparam logic signed [13:0] DIV_OFS  = 14'sd56;
   localparam logic signed [13:0] DEN_X    = -14'sd1077;

   svdac_pkg::state_type state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   svdac_pkg::cmd_type cmd_ff, cmd_in;

   // Stack memory with a registered read port.
   logic [63:0]       stack_mem [STACK_DEPTH];
   logic [63:0]       rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     waddr, raddr;
   logic [63:0]       wdata;

   logic [63:0]       b_ff, b_in;
   logic              sa_ff, sa_in, sb_ff, sb_in, sign_ff, sign_in;
   logic signed [13:0] ea_ff, ea_in, eb_ff, eb_in, x_ff, x_in;
   logic [52:0]       ma_ff, ma_in, mb_ff, mb_in;
   logic [56:0]       op1_ff, op1_in, op2_ff, op2_in;
   logic [107:0]      w_ff, w_in;
   logic              sticky_ff, sticky_in;
   logic [5:0]        iter_ff, iter_in;
   logic [68:0]       prod_ff, prod_in;
   logic [53:0]       rem_ff, rem_in;
   logic [56:0]       quo_ff, quo_in;
   logic [63:0]       res_ff, res_in;
   logic [63:0]       emit_bits_ff, emit_bits_in;
   svdac_pkg::status_type emit_stat_ff, emit_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_bits_ff, rsp_bits_in;
   svdac_pkg::status_type rsp_stat_ff, rsp_stat_in;

   logic              req_fire, out_free;
   logic [CW-1:0]     cnt_m1, cnt_m2;
   svdac_pkg::special_type spec;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_m1   = count_ff - CW'(1);
   assign cnt_m2   = count_ff - CW'(2);
   assign spec     = svdac_pkg::fp_special(cmd_ff, rdata_ff, b_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_bits_ff;
   assign rsp_tuser  = rsp_stat_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         svdac_pkg::S_IDLE: begin
            if (req_fire) begin
               unique case (svdac_pkg::cmd_type'(req_tuser))
                  svdac_pkg::CMD_CONST:
                     if (count_ff >= DEPTH_C) state_in = svdac_pkg::S_EMIT;
                  svdac_pkg::CMD_ADD, svdac_pkg::CMD_SUB,
                  svdac_pkg::CMD_MUL, svdac_pkg::CMD_DIV:
                     state_in = (count_ff < CW'(2)) ? svdac_pkg::S_EMIT : svdac_pkg::S_READ_B;
                  svdac_pkg::CMD_NEG, svdac_pkg::CMD_RET:
                     state_in = (count_ff == '0) ? svdac_pkg::S_EMIT : svdac_pkg::S_READ_T;
                  default: state_in = svdac_pkg::S_IDLE;
               endcase
            end
         end
         svdac_pkg::S_READ_B: state_in = svdac_pkg::S_READ_A;
         svdac_pkg::S_READ_A: state_in = svdac_pkg::S_SETUP;
         svdac_pkg::S_SETUP: begin
            if (spec.hit) state_in = svdac_pkg::S_WRITE;
            else begin
               unique case (cmd_ff)
                  svdac_pkg::CMD_MUL: state_in = svdac_pkg::S_MUL_P;
                  svdac_pkg::CMD_DIV: state_in = svdac_pkg::S_PRENORM;
                  default:            state_in = svdac_pkg::S_ALIGN;
               endcase
            end
         end
         svdac_pkg::S_ALIGN:  state_in = svdac_pkg::S_ADDSUB;
         svdac_pkg::S_ADDSUB:
            state_in = (op1_ff == op2_ff && sa_ff != sb_ff) ? svdac_pkg::S_WRITE
                                                           : svdac_pkg::S_NORM;
         svdac_pkg::S_MUL_P: state_in = svdac_pkg::S_MUL_A;
         svdac_pkg::S_MUL_A:
            state_in = (iter_ff == 6'd3) ? svdac_pkg::S_NORM : svdac_pkg::S_MUL_P;
         svdac_pkg::S_PRENORM:
            if (ma_ff[52] && mb_ff[52]) state_in = svdac_pkg::S_DIV;
         svdac_pkg::S_DIV:
            if (iter_ff == 6'd56) state_in = svdac_pkg::S_NORM;
         svdac_pkg::S_NORM:
            if (w_ff[107:56] == '0 && w_ff[55]) state_in = svdac_pkg::S_DENORM;
         svdac_pkg::S_DENORM: state_in = svdac_pkg::S_ROUND;
         svdac_pkg::S_ROUND:  state_in = svdac_pkg::S_WRITE;
         svdac_pkg::S_WRITE:  state_in = svdac_pkg::S_IDLE;
         svdac_pkg::S_READ_T: state_in = svdac_pkg::S_TOP;
         svdac_pkg::S_TOP:
            state_in = (cmd_ff == svdac_pkg::CMD_RET) ? svdac_pkg::S_EMIT : svdac_pkg::S_IDLE;
         svdac_pkg::S_EMIT:
            if (out_free) state_in = svdac_pkg::S_IDLE;
         default: state_in = svdac_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and memory port control.
   always_comb begin
      req_tready = (state_ff == svdac_pkg::S_IDLE);
      mem_we     = 1'b0;
      waddr      = count_ff[AW-1:0];
      wdata      = req_tdata;
      raddr      = cnt_m1[AW-1:0];
      unique case (state_ff)
         svdac_pkg::S_IDLE:
            mem_we = req_fire && (svdac_pkg::cmd_type'(req_tuser) == svdac_pkg::CMD_CONST)
                     && (count_ff < DEPTH_C);
         svdac_pkg::S_READ_A: raddr = cnt_m2[AW-1:0];
         svdac_pkg::S_WRITE: begin
            mem_we = 1'b1;
            waddr  = cnt_m2[AW-1:0];
            wdata  = res_ff;
         end
         svdac_pkg::S_TOP: begin
            mem_we = (cmd_ff == svdac_pkg::CMD_NEG);
            waddr  = cnt_m1[AW-1:0];
            wdata  = rdata_ff ^ svdac_pkg::SIGN_BIT;
         end
         default: ;
      endcase
   end

   // Datapath of the shared floating-point unit and the stack pointer.
   always_comb begin
      logic signed [13:0] diff, dabs, be, amt;
      logic [5:0]         sh;
      logic [63:0]        wide;
      logic [57:0]        dif58;
      logic [15:0]        chunk;
      logic               ge, up, gbit, stk;
      logic [53:0]        rsub, mant;
      logic [63:0]        sum;
      logic [11:0]        bem1;
      diff  = '0; dabs = '0; be = '0; amt = '0; sh = '0; wide = '0; dif58 = '0;
      chunk = '0; ge = 1'b0; up = 1'b0; gbit = 1'b0; stk = 1'b0; rsub = '0;
      mant  = '0; sum = '0; bem1 = '0;

      count_in     = count_ff;
      cmd_in       = cmd_ff;
      b_in         = b_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      sign_in      = sign_ff;
      ea_in        = ea_ff;
      eb_in        = eb_ff;
      x_in         = x_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      op1_in       = op1_ff;
      op2_in       = op2_ff;
      w_in         = w_ff;
      sticky_in    = sticky_ff;
      iter_in      = iter_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      res_in       = res_ff;
      emit_bits_in = emit_bits_ff;
      emit_stat_in = emit_stat_ff;

      unique case (state_ff)
         svdac_pkg::S_IDLE: begin
            if (req_fire) begin
               cmd_in       = svdac_pkg::cmd_type'(req_tuser);
               emit_bits_in = 64'd0;
               emit_stat_in = svdac_pkg::STAT_UNDER;
               if (svdac_pkg::cmd_type'(req_tuser) == svdac_pkg::CMD_CONST) begin
                  if (count_ff >= DEPTH_C) emit_stat_in = svdac_pkg::STAT_OVER;
                  else count_in = count_ff + CW'(1);
               end
            end
         end
         svdac_pkg::S_READ_A: b_in = rdata_ff;
         svdac_pkg::S_SETUP: begin
            res_in    = spec.bits;
            sa_in     = rdata_ff[63];
            sb_in     = b_ff[63] ^ (cmd_ff == svdac_pkg::CMD_SUB);
            ea_in     = (rdata_ff[62:52] == '0) ? 14'sd1 : $signed({3'b000, rdata_ff[62:52]});
            eb_in     = (b_ff[62:52] == '0) ? 14'sd1 : $signed({3'b000, b_ff[62:52]});
            ma_in     = {rdata_ff[62:52] != '0, rdata_ff[51:0]};
            mb_in     = {b_ff[62:52] != '0, b_ff[51:0]};
            sign_in   = rdata_ff[63] ^ b_ff[63];
            w_in      = '0;
            sticky_in = 1'b0;
            iter_in   = '0;
         end
         svdac_pkg::S_ALIGN: begin
            // The operand with the larger exponent stays; the other is shifted
            // right with its lost bits folded into the lowest bit.
            diff = ea_ff - eb_ff;
            dabs = (diff < 0) ? -diff : diff;
            sh   = (dabs > 14'sd63) ? 6'd63 : dabs[5:0];
            if (diff < 0) begin
               op1_in = {1'b0, mb_ff, 3'b000};
               wide   = svdac_pkg::shr_sticky({8'd0, ma_ff, 3'b000}, sh);
               sa_in  = sb_ff;
               sb_in  = sa_ff;
               x_in   = eb_ff - BIAS_OFS;
            end else begin
               op1_in = {1'b0, ma_ff, 3'b000};
               wide   = svdac_pkg::shr_sticky({8'd0, mb_ff, 3'b000}, sh);
               x_in   = ea_ff - BIAS_OFS;
            end
            op2_in = wide[56:0];
         end
         svdac_pkg::S_ADDSUB: begin
            if (sa_ff == sb_ff) begin
               w_in    = {51'd0, op1_ff + op2_ff};
               sign_in = sa_ff;
            end else begin
               dif58 = {1'b0, op1_ff} - {1'b0, op2_ff};
               if (dif58[57]) begin
                  dif58   = -dif58;
                  sign_in = sb_ff;
               end else begin
                  sign_in = sa_ff;
               end
               w_in = {50'd0, dif58};
            end
            // Exact cancellation rounds to positive zero.
            res_in = 64'd0;
         end
         svdac_pkg::S_MUL_P: begin
            unique case (iter_ff[1:0])
               2'd0: chunk = {11'd0, mb_ff[52:48]};
               2'd1: chunk = mb_ff[47:32];
               2'd2: chunk = mb_ff[31:16];
               2'd3: chunk = mb_ff[15:0];
               default: chunk = '0;
            endcase
            prod_in = ma_ff * chunk;
         end
         svdac_pkg::S_MUL_A: begin
            w_in    = (w_ff << 16) + {39'd0, prod_ff};
            iter_in = iter_ff + 6'd1;
            x_in    = ea_ff + eb_ff - MUL_OFS;
         end
         svdac_pkg::S_PRENORM: begin
            if (!ma_ff[52]) begin
               ma_in = ma_ff << 1;
               ea_in = ea_ff - 14'sd1;
            end
            if (!mb_ff[52]) begin
               mb_in = mb_ff << 1;
               eb_in = eb_ff - 14'sd1;
            end
            rem_in  = {1'b0, ma_ff};
            quo_in  = '0;
            iter_in = '0;
         end
         svdac_pkg::S_DIV: begin
            ge        = rem_ff >= {1'b0, mb_ff};
            rsub      = ge ? rem_ff - {1'b0, mb_ff} : rem_ff;
            rem_in    = rsub << 1;
            quo_in    = {quo_ff[55:0], ge};
            iter_in   = iter_ff + 6'd1;
            w_in      = {51'd0, quo_ff[55:0], ge};
            sticky_in = (rsub != '0);
            x_in      = ea_ff - eb_ff - DIV_OFS;
         end
         svdac_pkg::S_NORM: begin
            // Bring the leading one to bit 55, sixteen bits at a time where possible.
            priority if (w_ff[107:71] != '0) begin
               w_in      = w_ff >> 16;
               sticky_in = sticky_ff | (|w_ff[15:0]);
               x_in      = x_ff + 14'sd16;
            end else if (w_ff[107:56] != '0) begin
               w_in      = w_ff >> 1;
               sticky_in = sticky_ff | w_ff[0];
               x_in      = x_ff + 14'sd1;
            end else if (w_ff[55:40] == '0) begin
               w_in = w_ff << 16;
               x_in = x_ff - 14'sd16;
            end else if (!w_ff[55]) begin
               w_in = w_ff << 1;
               x_in = x_ff - 14'sd1;
            end else begin
               w_in = w_ff;
            end
         end
         svdac_pkg::S_DENORM: begin
            // Results below the normal range are shifted to the subnormal exponent.
            be = x_ff + BIAS_OFS;
            if (be < 14'sd1) begin
               amt = 14'sd1 - be;
               if (amt > 14'sd63) begin
                  w_in = {107'd0, |w_ff[55:0]};
               end else begin
                  wide = svdac_pkg::shr_sticky(w_ff[63:0], amt[5:0]);
                  w_in = {44'd0, wide};
               end
               x_in = DEN_X;
            end
         end
         svdac_pkg::S_ROUND: begin
            be   = x_ff + BIAS_OFS;
            gbit = w_ff[2];
            stk  = (|w_ff[1:0]) | sticky_ff;
            up   = gbit & (stk | w_ff[3]);
            mant = {1'b0, w_ff[55:3]} + {53'd0, up};
            if (be >= 14'sd2047) begin
               res_in = {sign_ff, svdac_pkg::EXP_ONES, 52'd0};
            end else begin
               bem1 = 12'(be - 14'sd1);
               sum  = {bem1, 52'd0} + {10'd0, mant};
               if (sum[63:52] >= 12'd2047) res_in = {sign_ff, svdac_pkg::EXP_ONES, 52'd0};
               else res_in = {sign_ff, sum[62:0]};
            end
         end
         svdac_pkg::S_WRITE: count_in = cnt_m1;
         svdac_pkg::S_TOP: begin
            if (cmd_ff == svdac_pkg::CMD_RET) begin
               emit_bits_in = rdata_ff;
               emit_stat_in = svdac_pkg::STAT_OK;
               count_in     = '0;
            end
         end
         default: ;
      endcase
   end

   // Output register: a result waits here until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (state_ff == svdac_pkg::S_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_bits_in  = emit_bits_ff;
         rsp_stat_in  = emit_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[waddr] <= wdata;
      rdata_ff <= stack_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svdac_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      b_ff         <= b_in;
      sa_ff        <= sa_in;
      sb_ff        <= sb_in;
      sign_ff      <= sign_in;
      ea_ff        <= ea_in;
      eb_ff        <= eb_in;
      x_ff         <= x_in;
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      op1_ff       <= op1_in;
      op2_ff       <= op2_in;
      w_ff         <= w_in;
      sticky_ff    <= sticky_in;
      iter_ff      <= iter_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      res_ff       <= res_in;
      emit_bits_ff <= emit_bits_in;
      emit_stat_ff <= emit_stat_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

endmodule

@@ hdl/svdac_checker.sv @@
`include "stack_vm_double_arith_core_defines.svh"

module svdac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic req_fire;
   logic arith_cmd;
   assign req_fire  = req_tvalid && req_tready;
   assign arith_cmd = (req_tuser == svdac_pkg::CMD_ADD) || (req_tuser == svdac_pkg::CMD_SUB) ||
                      (req_tuser == svdac_pkg::CMD_MUL) || (req_tuser == svdac_pkg::CMD_DIV);

   `SVDAC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")
   `SVDAC_ASSERT_NEXT(a_busy_after_arith, req_fire && arith_cmd, !req_tready, "ready right after arithmetic")
   `SVDAC_ASSERT_NEXT(a_nop_idle, req_fire && req_tuser == svdac_pkg::CMD_NOP, req_tready, "unknown command stalled")
   `SVDAC_ASSERT_NOW(a_err_zero, rsp_tvalid && rsp_tuser != svdac_pkg::STAT_OK, rsp_tdata == 64'd0, "error result not zero")

endmodule

bind stack_vm_double_arith_core svdac_checker u_svdac_checker (.*);

@@ dv/tb_top.sv @@
// Testbench for the double-precision bytecode stack machine.
//
// The sender drives one instruction per transaction on the req_* channel. A
// predictor in this module keeps its own copy of the operand stack and
// computes the expected result of every accepted instruction. A separate
// process compares each transaction on the rsp_* channel with the oldest
// expected result. Both channels stall in random bursts, and once the
// receiver holds off for a long stretch so that the block backs up.
module tb_top;

   localparam int DEPTH = svdac_pkg::STACK_DEPTH;
   localparam logic [63:0] EXP_FIELD = 64'h7FF0_0000_0000_0000;

   typedef struct {
      logic [63:0]           bits;
      svdac_pkg::status_type st;
   } vm_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = 64'd0;              // [63:0] constant_bits
   logic [2:0]  req_tuser = svdac_pkg::CMD_NOP; // [2:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;                      // [63:0] result_bits
   logic [1:0]  rsp_tuser;                      // [1:0] status

   // Predicted machine state.
   logic [63:0]   vm_stack [DEPTH];
   int            vm_depth = 0;
   vm_result_type pending_results [$];

   int errors = 0;
   bit quiet = 1'b0;     // no idling on either side when set
   bit hold_req = 1'b0;  // asks the receiver for one long hold-off

   stack_vm_double_arith_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic bit is_nan64(input logic [63:0] v);
      return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
   endfunction

   // Arithmetic on binary64 values. The simulator's real type carries the
   // IEEE rounding; NaN operands and division by zero are resolved here so
   // that the payloads do not depend on the host.
   function automatic logic [63:0] double_arith(input svdac_pkg::cmd_type op,
                                                input logic [63:0] a,
                                                input logic [63:0] b);
      real         x;
      real         y;
      real         r;
      logic [63:0] rb;
      if (op == svdac_pkg::CMD_DIV && b[62:0] == 63'd0) begin
         if (is_nan64(a)) return a | svdac_pkg::QUIET_BIT;
         if (a[62:0] == 63'd0) return svdac_pkg::DEFAULT_NAN;
         return ((a ^ b) & svdac_pkg::SIGN_BIT) | EXP_FIELD;
      end
      if (is_nan64(a)) return a | svdac_pkg::QUIET_BIT;
      if (is_nan64(b)) return b | svdac_pkg::QUIET_BIT;
      x = $bitstoreal(a);
      y = $bitstoreal(b);
      case (op)
         svdac_pkg::CMD_ADD: r = x + y;
         svdac_pkg::CMD_SUB: r = x - y;
         svdac_pkg::CMD_MUL: r = x * y;
         default:            r = x / y;
      endcase
      rb = $realtobits(r);
      // An invalid operation such as infinity minus infinity yields the
      // negative default NaN.
      if (is_nan64(rb)) rb = svdac_pkg::INVALID_NAN;
      return rb;
   endfunction

   // Applies one accepted instruction to the predicted stack and queues the
   // result it causes, if any.
   task automatic execute_instr(input svdac_pkg::cmd_type op, input logic [63:0] k);
      vm_result_type res;
      res.bits = 64'd0;
      res.st   = svdac_pkg::STAT_UNDER;
      case (op)
         svdac_pkg::CMD_CONST: begin
            if (vm_depth >= DEPTH) begin
               res.st = svdac_pkg::STAT_OVER;
               pending_results.push_back(res);
            end else begin
               vm_stack[vm_depth] = k;
               vm_depth++;
            end
         end
         svdac_pkg::CMD_ADD, svdac_pkg::CMD_SUB, svdac_pkg::CMD_MUL, svdac_pkg::CMD_DIV: begin
            if (vm_depth < 2) begin
               pending_results.push_back(res);
            end else begin
               vm_stack[vm_depth-2] = double_arith(op, vm_stack[vm_depth-2],
                                                  vm_stack[vm_depth-1]);
               vm_depth--;
            end
         end
         svdac_pkg::CMD_NEG: begin
            if (vm_depth < 1) pending_results.push_back(res);
            else vm_stack[vm_depth-1] ^= svdac_pkg::SIGN_BIT;
         end
         svdac_pkg::CMD_RET: begin
            if (vm_depth >= 1) begin
               res.bits = vm_stack[vm_depth-1];
               res.st   = svdac_pkg::STAT_OK;
               vm_depth = 0;
            end
            pending_results.push_back(res);
         end
         default: ;
      endcase
   endtask

   // Offers one instruction and waits for the block to take it. The valid
   // stays high into the next call unless an idle burst follows.
   task automatic send_instr(input svdac_pkg::cmd_type op, input logic [63:0] k);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= k;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      execute_instr(op, k);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Operand values: raw bit patterns, ordinary numbers and the special encodings
   // (infinity, zero, subnormal, NaN), the last group the most often.
   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return {$urandom, $urandom};
         3, 4: return $realtobits(real'($urandom_range(0, 2000)) - 1000.0);
         5: return $realtobits((real'($urandom) - 2147483648.0) / 65536.0);
         6: return {1'($urandom_range(0, 1)), 11'h7FF, 52'd0};
         7: return {1'($urandom_range(0, 1)), 63'd0};
         8: return {1'($urandom_range(0, 1)), 11'h000, 20'($urandom), 32'($urandom)};
         default: return {1'($urandom_range(0, 1)), 11'h7FF, 20'($urandom),
                          32'($urandom) | 32'd1};
      endcase
   endfunction

   // Receiver: random stall bursts, and one long hold-off on request.
   initial begin
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 1'b0;
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      vm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result bits %h status %0d",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.bits) begin
               $display("%0t: result bits expected %h actual %h",
                        $time, want.bits, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.st) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.st, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Extremes, every command, and each special case.
   task automatic test_directed();
      send_instr(svdac_pkg::CMD_ADD, 64'd0);                      // underflow on empty stack
      send_instr(svdac_pkg::CMD_NEG, 64'd0);
      send_instr(svdac_pkg::CMD_RET, 64'd0);
      send_instr(svdac_pkg::CMD_NOP, 64'hFFFF_FFFF_FFFF_FFFF);    // ignored
      send_instr(svdac_pkg::CMD_CONST, 64'hFFFF_FFFF_FFFF_FFFF);  // a NaN with every bit set
      send_instr(svdac_pkg::CMD_DIV, 64'd0);                      // one entry is not enough
      send_instr(svdac_pkg::CMD_NEG, 64'd0);                      // sign flip keeps the payload
      send_instr(svdac_pkg::CMD_RET, 64'd0);
      send_instr(svdac_pkg::CMD_CONST, $realtobits(1.5));
      send_instr(svdac_pkg::CMD_CONST, $realtobits(2.25));
      send_instr(svdac_pkg::CMD_ADD, 64'd0);
      send_instr(svdac_pkg::CMD_CONST, 64'h7FEF_FFFF_FFFF_FFFF); // largest finite
      send_instr(svdac_pkg::CMD_MUL, 64'd0);                      // overflows to infinity
      send_instr(svdac_pkg::CMD_CONST, 64'h0000_0000_0000_0001); // smallest subnormal
      send_instr(svdac_pkg::CMD_SUB, 64'd0);
      send_instr(svdac_pkg::CMD_CONST, 64'h8000_0000_0000_0000); // negative zero
      send_instr(svdac_pkg::CMD_DIV, 64'd0);                      // infinity by zero
      send_instr(svdac_pkg::CMD_RET, 64'd0);
      // Zero by zero, then a NaN by zero.
      send_instr(svdac_pkg::CMD_CONST, 64'd0);
      send_instr(svdac_pkg::CMD_CONST, 64'd0);
      send_instr(svdac_pkg::CMD_DIV, 64'd0);
      send_instr(svdac_pkg::CMD_CONST, 64'd0);
      send_instr(svdac_pkg::CMD_DIV, 64'd0);
      send_instr(svdac_pkg::CMD_RET, 64'd0);
   endtask

   // Fills the stack to the brim and pushes once more.
   task automatic test_overflow();
      repeat (DEPTH) send_instr(svdac_pkg::CMD_CONST, pick_value());
      send_instr(svdac_pkg::CMD_CONST, $realtobits(3.0));
      send_instr(svdac_pkg::CMD_MUL, 64'd0);
      send_instr(svdac_pkg::CMD_RET, 64'd0);
   endtask

   // Short well-formed programs with random content, mixed with noise.
   task automatic run_programs(input int n_items);
      int                 sent;
      int                 len;
      svdac_pkg::cmd_type op;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_instr(svdac_pkg::cmd_type'($urandom_range(0, 7)), {$urandom, $urandom});
            sent++;
         end else begin
            len = $urandom_range(1, 12);
            repeat (len) begin
               if (vm_depth < 2 || $urandom_range(0, 2) == 0) begin
                  send_instr(svdac_pkg::CMD_CONST, pick_value());
               end else begin
                  op = svdac_pkg::cmd_type'($urandom_range(1, 5));
                  send_instr(op, {$urandom, $urandom});
               end
               sent++;
            end
            send_instr(svdac_pkg::CMD_RET, {$urandom, $urandom});
            sent++;
         end
      end
   endtask

   // The receiver holds off while the sender keeps offering short programs.
   task automatic test_backpressure();
      hold_req = 1'b1;
      quiet    = 1'b1;
      repeat (20) begin
         send_instr(svdac_pkg::CMD_CONST, pick_value());
         send_instr(svdac_pkg::CMD_RET, 64'd0);
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      run_programs(400);
      test_backpressure();
      run_programs(330);
      quiet = 1'b1;
      run_programs(100);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(20 * 3_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
